/* rtl/hga_pkg.sv */
// Package with shared constants, types and the hash multiplier constants.
package hga_pkg;

  localparam int unsigned SlotsLog2 = 16;
  localparam int unsigned KeyW = 64;
  localparam int unsigned AggW = 31 + 31 + 15 + 15 + 31 + 31;
  localparam int unsigned UsedW = SlotsLog2 + 1;

  localparam logic [63:0] MixAdd = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2 = 64'h94d049bb133111eb;

  localparam logic [30:0] Max31 = 31'h7fffffff;
  localparam logic [14:0] OrderMax = 15'h7fff;
  localparam logic [16:0] LimitReset = 17'd47185;

  localparam logic [1:0] StUpdated = 2'd0;
  localparam logic [1:0] StCreated = 2'd1;
  localparam logic [1:0] StDropped = 2'd2;
  localparam logic [1:0] StRead = 2'd3;

  typedef struct packed {
    logic [30:0] purchase;
    logic [30:0] reorder;
    logic [14:0] min_ord;
    logic [14:0] max_ord;
    logic [30:0] cart_total;
    logic [30:0] cart_count;
  } agg_t;

  function automatic logic [30:0] sat_add31(input logic [30:0] a, input logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add31 = s[31] ? Max31 : s[30:0];
  endfunction

endpackage

/* rtl/hga_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module hga_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

/* rtl/hga_hash.sv */
// Multi-cycle splitmix64 hash unit, split into 32-bit partial products.
module hga_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  output logic        done_o,
  output logic [63:0] hash_o
);

  // Each 64x64 product (low 64 bits) takes three 32x32 partial products.
  logic [63:0] v_q, v_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] mul_c;
  logic [31:0] pa, pb;
  logic [63:0] prod;

  assign mul_c = (step_q < 4'd3) ? hga_pkg::MixMul1 : hga_pkg::MixMul2;

  always_comb begin
    case (step_q)
      4'd0, 4'd3: begin pa = v_q[31:0];  pb = mul_c[31:0];  end
      4'd1, 4'd4: begin pa = v_q[63:32]; pb = mul_c[31:0];  end
      default:    begin pa = v_q[31:0];  pb = mul_c[63:32]; end
    endcase
  end

  assign prod = {32'd0, pa} * {32'd0, pb};

  always_comb begin
    v_d = v_q;
    acc_d = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d = key_i + hga_pkg::MixAdd;
      v_d = v_d ^ (v_d >> 30);
      acc_d = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      case (step_q)
        4'd0, 4'd3: begin acc_d = prod; step_d = step_q + 4'd1; end
        4'd1, 4'd4: begin
          acc_d = acc_q + {prod[31:0], 32'd0};
          step_d = step_q + 4'd1;
        end
        4'd2: begin
          acc_d = acc_q + {prod[31:0], 32'd0};
          v_d = acc_d ^ (acc_d >> 27);
          step_d = 4'd3;
        end
        default: begin
          acc_d = acc_q + {prod[31:0], 32'd0};
          v_d = acc_d ^ (acc_d >> 31);
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  // The finished hash sits in v_q in the cycle that done_o marks.
  assign hash_o = v_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    acc_q <= acc_d;
  end

endmodule

/* rtl/hash_group_by_aggregator_unit.sv */
// Top level of the hash group-by aggregator.
// After reset the unit sweeps the key memory clear, one slot per cycle, and
// holds busy_o high meanwhile. A read request holds busy_o through SSlotR
// and SSlotO after it is accepted, and its result shows in the cycle after
// that. An accumulate request waits in SHash for the hash (three 32-bit
// partial products per 64-bit multiply), then passes SRead and SProbe per
// probed slot through the single-port key memory, then SWrite and SSlotO to
// update and report; a dropped row skips SWrite. Its result shows in the last
// busy cycle, SSlotO, for a dropped row too. The result appears for one
// cycle with result_valid_o; the receiver cannot stall it.
module hash_group_by_aggregator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [31:0] customer_id_i,
  input  logic [31:0] product_id_i,
  input  logic [14:0] order_number_i,
  input  logic [9:0]  cart_position_i,
  input  logic        reordered_flag_i,
  input  logic [15:0] read_slot_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] slot_index_o,
  output logic        slot_valid_o,
  output logic [31:0] key_customer_o,
  output logic [31:0] key_product_o,
  output logic [30:0] row_total_o,
  output logic [30:0] repeat_total_o,
  output logic [14:0] min_order_o,
  output logic [14:0] max_order_o,
  output logic [30:0] cart_pos_total_o,
  output logic [30:0] cart_count_o,
  output logic [16:0] entries_used_o
);

  localparam int unsigned SL = hga_pkg::SlotsLog2;

  typedef enum logic [7:0] {
    SClear = 8'b0000_0001,
    SIdle  = 8'b0000_0010,
    SHash  = 8'b0000_0100,
    SRead  = 8'b0000_1000,
    SProbe = 8'b0001_0000,
    SWrite = 8'b0010_0000,
    SSlotR = 8'b0100_0000,
    SSlotO = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [SL-1:0] idx_q, idx_d, home_q, home_d;
  logic [SL:0]   steps_q, steps_d;
  logic [hga_pkg::UsedW-1:0] used_q, used_d;
  logic [16:0] limit_q;
  logic [63:0] k_q;
  logic [63:0] key_in;
  logic        req_q;
  logic [31:0] cust_q, prod_q;
  logic [14:0] onum_q;
  logic [9:0]  cart_q;
  logic        reo_q;
  logic        found_q, found_d;

  logic        hstart, hdone;
  logic [63:0] hash;

  logic        key_we, agg_we;
  logic [SL-1:0] addr;
  logic [63:0] key_wd, key_rd;
  hga_pkg::agg_t agg_wd, agg_rd, agg_base;

  logic          out_v_q;
  logic [1:0]    out_st_q;
  logic [SL-1:0] out_slot_q;
  logic          out_sv_q;
  logic [63:0]   out_key_q;
  hga_pkg::agg_t out_agg_q;

  logic accept;
  assign accept = start_i && state_q == SIdle;
  assign busy_o = state_q != SIdle;

  // The stored key is the packed key plus one, so zero marks an empty slot.
  assign key_in = {customer_id_i, product_id_i} + 64'd1;

  hga_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hstart),
    .key_i  (key_in),
    .done_o (hdone),
    .hash_o (hash)
  );

  hga_ram #(.Width(hga_pkg::KeyW), .Depth(1 << SL)) u_key_ram (
    .clk_i(clk_i), .we_i(key_we), .addr_i(addr), .wdata_i(key_wd), .rdata_o(key_rd)
  );

  hga_ram #(.Width(hga_pkg::AggW), .Depth(1 << SL)) u_agg_ram (
    .clk_i(clk_i), .we_i(agg_we), .addr_i(addr), .wdata_i(agg_wd), .rdata_o(agg_rd)
  );

  // A new entry starts from the initial aggregate instead of the stored one.
  always_comb begin
    if (found_q) begin
      agg_base = agg_rd;
    end else begin
      agg_base = '{purchase: '0, reorder: '0, min_ord: hga_pkg::OrderMax,
                   max_ord: '0, cart_total: '0, cart_count: '0};
    end
    agg_wd.purchase = hga_pkg::sat_add31(agg_base.purchase, 31'd1);
    agg_wd.reorder = hga_pkg::sat_add31(agg_base.reorder, {30'd0, reo_q});
    agg_wd.min_ord = (onum_q < agg_base.min_ord) ? onum_q : agg_base.min_ord;
    agg_wd.max_ord = (onum_q > agg_base.max_ord) ? onum_q : agg_base.max_ord;
    agg_wd.cart_total = hga_pkg::sat_add31(agg_base.cart_total, {21'd0, cart_q});
    agg_wd.cart_count = hga_pkg::sat_add31(agg_base.cart_count, 31'd1);
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    home_d = home_q;
    steps_d = steps_q;
    used_d = used_q;
    found_d = found_q;
    hstart = 1'b0;
    key_we = 1'b0;
    agg_we = 1'b0;
    key_wd = '0;
    addr = idx_q;
    case (state_q)
      SClear: begin
        key_we = 1'b1;
        idx_d = idx_q + SL'(1);
        if (&idx_q) state_d = SIdle;
      end
      SIdle: begin
        if (accept) begin
          if (req_type_i) begin
            idx_d = read_slot_i[SL-1:0];
            found_d = 1'b1;
            state_d = SSlotR;
          end else begin
            state_d = SHash;
            hstart = 1'b1;
          end
        end
      end
      SHash: begin
        if (hdone) begin
          home_d = hash[SL-1:0];
          idx_d = hash[SL-1:0];
          steps_d = '0;
          state_d = SRead;
        end
      end
      SRead: begin
        state_d = SProbe;
      end
      SProbe: begin
        if (k_q == 64'd0 || steps_q[SL]) begin
          state_d = SSlotO;
        end else if (key_rd == k_q) begin
          found_d = 1'b1;
          state_d = SWrite;
        end else if (key_rd == 64'd0) begin
          found_d = 1'b0;
          state_d = (used_q >= limit_q) ? SSlotO : SWrite;
        end else begin
          idx_d = idx_q + SL'(1);
          steps_d = steps_q + (SL + 1)'(1);
          state_d = SRead;
        end
      end
      SWrite: begin
        key_we = 1'b1;
        key_wd = k_q;
        agg_we = 1'b1;
        if (!found_q) used_d = used_q + {{(hga_pkg::UsedW - 1){1'b0}}, 1'b1};
        state_d = SSlotO;
      end
      SSlotR: begin
        state_d = SSlotO;
      end
      SSlotO: begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // A probe that ends in SSlotO without a write is a dropped row.
  logic drop;
  assign drop = state_q == SProbe && state_d == SSlotO;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      idx_q <= '0;
      used_q <= '0;
      limit_q <= hga_pkg::LimitReset;
      out_v_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      used_q <= used_d;
      found_q <= found_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      out_v_q <= drop || state_q == SWrite || (state_q == SSlotO && req_q);
      if (drop) begin
        out_st_q <= hga_pkg::StDropped;
        out_slot_q <= home_q;
        out_sv_q <= 1'b0;
        out_key_q <= {cust_q, prod_q};
        out_agg_q <= '0;
      end else if (state_q == SWrite) begin
        out_st_q <= found_q ? hga_pkg::StUpdated : hga_pkg::StCreated;
        out_slot_q <= idx_q;
        out_sv_q <= 1'b1;
        out_key_q <= {cust_q, prod_q};
        out_agg_q <= agg_wd;
      end else if (state_q == SSlotO && req_q) begin
        out_st_q <= hga_pkg::StRead;
        out_slot_q <= idx_q;
        out_sv_q <= key_rd != 64'd0;
        out_key_q <= (key_rd != 64'd0) ? key_rd - 64'd1 : 64'd0;
        out_agg_q <= (key_rd != 64'd0) ? agg_rd : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    home_q <= home_d;
    steps_q <= steps_d;
    if (accept) begin
      req_q <= req_type_i;
      cust_q <= customer_id_i;
      prod_q <= product_id_i;
      onum_q <= order_number_i;
      cart_q <= cart_position_i;
      reo_q <= reordered_flag_i;
      k_q <= key_in;
    end
  end

  assign result_valid_o = out_v_q;
  assign status_o = out_st_q;
  assign slot_index_o = 16'(out_slot_q);
  assign slot_valid_o = out_sv_q;
  assign key_customer_o = out_key_q[63:32];
  assign key_product_o = out_key_q[31:0];
  assign row_total_o = out_agg_q.purchase;
  assign repeat_total_o = out_agg_q.reorder;
  assign min_order_o = out_agg_q.min_ord;
  assign max_order_o = out_agg_q.max_ord;
  assign cart_pos_total_o = out_agg_q.cart_total;
  assign cart_count_o = out_agg_q.cart_count;
  assign entries_used_o = 17'(used_q);

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == $past(used_q) ||
    used_q == $past(used_q) + {{(hga_pkg::UsedW - 1){1'b0}}, 1'b1})
    else $error("used count changed by more than one");
  a_no_create_over_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWrite && !found_q) |-> used_q < limit_q)
    else $error("entry created at or above occupancy limit");
  a_result_in_last_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == SSlotO || state_q == SIdle))
    else $error("result shown before the request finished");

endmodule
